### sv/cpu_alu_with_flags_assert.svh
// Assertion macros for the ALU block.
// No dependencies; included by files that carry concurrent checks.
`ifndef CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define CAF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, clocked on clk, quiet during reset.
`define CAF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

### sv/cpualu_pkg.sv
// Shared types and constants for the ALU block: operation codes, flag
// positions and the operand / result bundles. No dependencies.
package cpualu_pkg;

  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_ADC     = 5'd1,
    OP_SUB     = 5'd2,
    OP_SBC     = 5'd3,
    OP_AND     = 5'd4,
    OP_XOR     = 5'd5,
    OP_OR      = 5'd6,
    OP_CP      = 5'd7,
    OP_INC     = 5'd8,
    OP_DEC     = 5'd9,
    OP_RLCA    = 5'd10,
    OP_RRCA    = 5'd11,
    OP_RLA     = 5'd12,
    OP_RRA     = 5'd13,
    OP_RLC     = 5'd14,
    OP_RRC     = 5'd15,
    OP_RL      = 5'd16,
    OP_RR      = 5'd17,
    OP_SLA     = 5'd18,
    OP_SRA     = 5'd19,
    OP_SWAP    = 5'd20,
    OP_SRL     = 5'd21,
    OP_BIT     = 5'd22,
    OP_RES     = 5'd23,
    OP_SET     = 5'd24,
    OP_ADDHL   = 5'd25,
    OP_ADDSP   = 5'd26,
    OP_INC16   = 5'd27,
    OP_DEC16   = 5'd28
  } op_t;

  // Flag bit positions within the 4-bit flag word.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        writes_result;
  } alu_res_t;

endpackage

### sv/cpualu_core.sv
// Combinational datapath of the ALU: one operation, its result and flags.
// Depends on cpualu_pkg.
module cpualu_core (
  input  cpualu_pkg::alu_in_t  op,
  output cpualu_pkg::alu_res_t res
);
  import cpualu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        use_c;
  logic [8:0]  sum8;
  logic [4:0]  sum4;
  logic [8:0]  dif8;
  logic [4:0]  dif4;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [8:0]  sp_lo;
  logic [4:0]  sp_nib;
  logic [7:0]  bmask;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic [3:0]  f;
  logic        wr;
  logic        wide;

  assign a     = op.operand_a[7:0];
  assign b     = op.operand_b[7:0];
  assign cin   = op.flags_in[FLAG_C];
  assign use_c = (op.mode == OP_ADC) || (op.mode == OP_SBC);

  assign sum8   = {1'b0, a} + {1'b0, b} + {8'd0, use_c & cin};
  assign sum4   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_c & cin};
  assign dif8   = {1'b0, a} - {1'b0, b} - {8'd0, use_c & cin};
  assign dif4   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_c & cin};
  assign sum16  = {1'b0, op.operand_a} + {1'b0, op.operand_b};
  assign sum12  = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
  assign sp_lo  = {1'b0, op.operand_a[7:0]} + {1'b0, b};
  assign sp_nib = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
  assign bmask  = 8'd1 << op.bit_index;

  always_comb begin
    r8   = 8'd0;
    r16  = 16'd0;
    f    = op.flags_in;
    wr   = 1'b1;
    wide = 1'b0;
    case (op.mode)
      OP_ADD, OP_ADC: begin
        r8 = sum8[7:0];
        f  = {r8 == 8'd0, 1'b0, sum4[4], sum8[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8 = dif8[7:0];
        f  = {r8 == 8'd0, 1'b1, dif4[4], dif8[8]};
        wr = (op.mode != OP_CP);
      end
      OP_AND: begin
        r8 = a & b;
        f  = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r8 = a ^ b;
        f  = {r8 == 8'd0, 3'b000};
      end
      OP_OR: begin
        r8 = a | b;
        f  = {r8 == 8'd0, 3'b000};
      end
      OP_INC: begin
        r8 = a + 8'd1;
        f  = {r8 == 8'd0, 1'b0, a[3:0] == 4'hf, cin};
      end
      OP_DEC: begin
        r8 = a - 8'd1;
        f  = {r8 == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
      end
      OP_RLCA, OP_RLC: begin
        r8 = {a[6:0], a[7]};
        f  = {(op.mode == OP_RLC) && (r8 == 8'd0), 2'b00, a[7]};
      end
      OP_RRCA, OP_RRC: begin
        r8 = {a[0], a[7:1]};
        f  = {(op.mode == OP_RRC) && (r8 == 8'd0), 2'b00, a[0]};
      end
      OP_RLA, OP_RL: begin
        r8 = {a[6:0], cin};
        f  = {(op.mode == OP_RL) && (r8 == 8'd0), 2'b00, a[7]};
      end
      OP_RRA, OP_RR: begin
        r8 = {cin, a[7:1]};
        f  = {(op.mode == OP_RR) && (r8 == 8'd0), 2'b00, a[0]};
      end
      OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        f  = {r8 == 8'd0, 2'b00, a[7]};
      end
      OP_SRA: begin
        r8 = {a[7], a[7:1]};
        f  = {r8 == 8'd0, 2'b00, a[0]};
      end
      OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        f  = {r8 == 8'd0, 3'b000};
      end
      OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        f  = {r8 == 8'd0, 2'b00, a[0]};
      end
      OP_BIT: begin
        r8 = a;
        f  = {(a & bmask) == 8'd0, 1'b0, 1'b1, cin};
        wr = 1'b0;
      end
      OP_RES: r8 = a & ~bmask;
      OP_SET: r8 = a | bmask;
      OP_ADDHL: begin
        wide = 1'b1;
        r16  = sum16[15:0];
        f    = {op.flags_in[FLAG_Z], 1'b0, sum12[12], sum16[16]};
      end
      OP_ADDSP: begin
        wide = 1'b1;
        r16  = op.operand_a + {{8{b[7]}}, b};
        f    = {2'b00, sp_nib[4], sp_lo[8]};
      end
      OP_INC16: begin
        wide = 1'b1;
        r16  = op.operand_a + 16'd1;
      end
      OP_DEC16: begin
        wide = 1'b1;
        r16  = op.operand_a - 16'd1;
      end
      default: begin
        // Unused codes: zero result, flags pass through, no write-back.
        wr = 1'b0;
      end
    endcase
  end

  assign res.result        = wide ? r16 : {8'd0, r8};
  assign res.flags_out     = f;
  assign res.writes_result = wr;

endmodule

### sv/cpu_alu_with_flags.sv
// Top level of the ALU block: input register, datapath, result register.
// Depends on cpualu_pkg, cpualu_core and cpu_alu_with_flags_assert.svh.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------
//   in      | in_valid / in_stall      | mode, operand_a, operand_b, bit_index,
//           |                          | flags_in
//   out     | out_valid / out_stall    | result, flags_out, writes_result
//
// out_valid rises once the item has moved from the input register, through the
// datapath, into the result register; that move waits while out is stalled and the result register is full.
// One item is accepted every cycle while out is not stalled.
// rst is synchronous, active high, and empties both register stages.
// When out stalls, the result register holds; the input register still fills
// once, and only then does in_stall rise.
module cpu_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  mode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [2:0]  bit_index,
  input  logic [3:0]  flags_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] result,
  output logic [3:0]  flags_out,
  output logic        writes_result
);
  import cpualu_pkg::*;

  // Stage 1: captured operands. Stage 2: computed result.
  logic     s1_valid;
  alu_in_t  s1_op;
  logic     s2_valid;
  alu_res_t s2_res;
  alu_res_t core_res;
  logic     s2_load;
  logic     s1_load;

  // Advance the result stage whenever it is empty or being drained.
  assign s2_load  = !s2_valid || !out_stall;
  // Take a new item when stage 1 is empty or moving on.
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;

  cpualu_core u_core (
    .op  (s1_op),
    .res (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  // Payload registers carry no reset; load only on an accepted item.
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_op <= '{mode: mode, operand_a: operand_a, operand_b: operand_b,
                 bit_index: bit_index, flags_in: flags_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      s2_res <= core_res;
    end
  end

  assign out_valid     = s2_valid;
  assign result        = s2_res.result;
  assign flags_out     = s2_res.flags_out;
  assign writes_result = s2_res.writes_result;

`include "cpu_alu_with_flags_assert.svh"

  // Back-pressure only when both stages are full and out is stalled.
  `CAF_ASSERT_IMPL(a_stall_cause, in_stall, s1_valid && s2_valid && out_stall)
  // An accepted item always lands in stage 1.
  `CAF_ASSERT_NEXT(a_accept_fill, in_valid && !in_stall, s1_valid)
  // A stage-1 item that moves on shows up on out next cycle.
  `CAF_ASSERT_NEXT(a_s1_to_out, s1_valid && s2_load, out_valid)

endmodule
